// ===== rtl/core/fbpa_pkg.sv =====
// Fixed block pool allocator: shared constants.
// Request, status and register codes, field widths and reset values.
// No dependencies.
`default_nettype none

package fbpa_pkg;

	// Default number of block slots backed by storage
	localparam int DEF_POOL_DEPTH = 256;

	// Field widths fixed by the interface
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int INDEX_W   = 8;
	localparam int ADDR_W    = 32;
	localparam int COUNT_W   = 9;
	localparam int BYTES_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_BLOCK = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd2;

	// Configuration reset values
	localparam logic [COUNT_W-1:0] RST_POOL_COUNT  = 9'd256;
	localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = 16'd16;
	localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = 32'd0;

endpackage

`default_nettype wire

// ===== rtl/core/fbpa_ram.sv =====
// Fixed block pool allocator: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle. No dependencies.
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/fixed_block_pool_allocator_core.sv =====
// Fixed block pool allocator: top level.
// Depends on fbpa_pkg and fbpa_ram.
//
// Hands out equal-sized blocks from a LIFO free list. Every transaction passes
// through a read stage, where the link memory's registered read of the list
// head completes, and then a working stage, where the next-state and result
// logic runs and the result is registered. A new request is taken only once
// the previous one has left the working stage, so the read and working stages
// never hold a request at the same time. A held result stalls the working
// stage and with it the acceptance of the request behind it. Never-used blocks
// are issued in order from a fill pointer, so no clearing pass runs after
// reset: the link memory holds only entries written by frees, and the
// allocated marks are flip-flops cleared at once by reset or by a reset-pool request.
// Configuration is taken at any edge with cfg_we high and must only be
// changed while the block is idle.
`default_nettype none

module fixed_block_pool_allocator_core
	import fbpa_pkg::*;
#(
	parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [REQ_W-1:0]     req_type,
	input  wire logic [INDEX_W-1:0]   block_index,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [STATUS_W-1:0]  status,
	output logic      [INDEX_W-1:0]   given_index,
	output logic      [ADDR_W-1:0]    given_address,
	output logic      [COUNT_W-1:0]   in_use,
	output logic      [COUNT_W-1:0]   peak_use
);

	localparam int IDX_W  = $clog2(POOL_DEPTH);
	localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int PROD_W = IDX_W + BYTES_W;
	localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(POOL_DEPTH);

	// Configuration registers
	logic [COUNT_W-1:0] pool_count_q;
	logic [BYTES_W-1:0] block_bytes_q;
	logic [ADDR_W-1:0]  pool_base_q;

	// Pool state
	logic [CNT_W-1:0]      head_q;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      use_q;
	logic [CNT_W-1:0]      peak_q;
	logic [POOL_DEPTH-1:0] mark_q;

	// Request pipeline
	logic               valid_s1;
	logic               valid_s2;
	logic [REQ_W-1:0]   req_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic               fire;

	// Link memory
	logic [IDX_W-1:0] link_rdata;
	logic             link_we;

	// Next-state and result logic
	logic [CNT_W-1:0]    listed;
	logic                take_list;
	logic                fill_room;
	logic [IDX_W-1:0]    blk;
	logic [IDX_W-1:0]    free_ix;
	logic                free_ok;
	logic [PROD_W-1:0]   prod;
	logic [ADDR_W-1:0]   blk_addr;
	logic [CNT_W-1:0]    head_d;
	logic [CNT_W-1:0]    fill_d;
	logic [CNT_W-1:0]    use_d;
	logic [CNT_W-1:0]    peak_d;
	logic                mark_set;
	logic                mark_clr;
	logic                mark_wipe;
	logic [STATUS_W-1:0] status_d;
	logic [INDEX_W-1:0]  gidx_d;
	logic [ADDR_W-1:0]   gaddr_d;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q  <= RST_POOL_COUNT;
			block_bytes_q <= RST_BLOCK_BYTES;
			pool_base_q   <= RST_POOL_BASE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_COUNT:  pool_count_q  <= cfg_wdata[COUNT_W-1:0];
				CFG_BLOCK_BYTES: block_bytes_q <= cfg_wdata[BYTES_W-1:0];
				CFG_POOL_BASE:   pool_base_q   <= cfg_wdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept only when both stages are empty, so the head read sees the committed head
	assign in_ready = !valid_s1 && !valid_s2;
	assign fire     = valid_s2 && (!out_valid || out_ready);

	// Advance the request through the read and working stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Hold the request payload for both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= REQ_NOP;
			idx_s1 <= '0;
		end else if (in_valid && in_ready) begin
			req_s1 <= req_type;
			idx_s1 <= block_index;
		end
	end

	// Link below each freed block; read continuously at the list head
	fbpa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(POOL_DEPTH)
	) u_link (
		.clk    (clk),
		.we     (link_we),
		.waddr  (free_ix),
		.wdata  (head_q[IDX_W-1:0]),
		.raddr  (head_q[IDX_W-1:0]),
		.rdata_q(link_rdata)
	);

	// Pick the block to hand out: freed list first, then the fill pointer
	assign listed    = fill_q - use_q;
	assign take_list = (listed != '0) && (head_q != EMPTY_MARK);
	assign fill_room = (fill_q != EMPTY_MARK) && (CMP_W'(fill_q) < CMP_W'(pool_count_q));
	assign blk       = take_list ? head_q[IDX_W-1:0] : fill_q[IDX_W-1:0];

	// Byte address of the chosen block
	assign prod     = {{BYTES_W{1'b0}}, blk} * {{IDX_W{1'b0}}, block_bytes_q};
	assign blk_addr = pool_base_q + ADDR_W'(prod);

	// Free checks: index inside the pool and currently marked
	assign free_ix = IDX_W'(idx_s1);
	assign free_ok = (32'(idx_s1) < 32'(POOL_DEPTH)) && mark_q[free_ix];

	assign link_we = fire && (req_s1 == REQ_FREE) && free_ok;

	// Work out next state and the result of the request in the working stage
	always_comb begin
		head_d    = head_q;
		fill_d    = fill_q;
		use_d     = use_q;
		peak_d    = peak_q;
		mark_set  = 1'b0;
		mark_clr  = 1'b0;
		mark_wipe = 1'b0;
		status_d  = ST_OK;
		gidx_d    = '0;
		gaddr_d   = '0;
		unique case (req_s1)
			REQ_ALLOC: begin
				if (take_list || fill_room) begin
					if (take_list) begin
						head_d = (listed > CNT_W'(1)) ? CNT_W'(link_rdata) : EMPTY_MARK;
					end else begin
						fill_d = fill_q + CNT_W'(1);
					end
					mark_set = 1'b1;
					use_d    = use_q + CNT_W'(1);
					peak_d   = (use_d > peak_q) ? use_d : peak_q;
					gidx_d   = INDEX_W'(blk);
					gaddr_d  = blk_addr;
				end else begin
					status_d = ST_EMPTY;
				end
			end
			REQ_FREE: begin
				if (free_ok) begin
					mark_clr = 1'b1;
					head_d   = CNT_W'(free_ix);
					use_d    = use_q - CNT_W'(1);
				end else begin
					status_d = ST_BAD_BLOCK;
				end
			end
			REQ_RESET: begin
				mark_wipe = 1'b1;
				head_d    = EMPTY_MARK;
				fill_d    = '0;
				use_d     = '0;
			end
			REQ_NOP: ;
		endcase
	end

	// Commit pool state when the result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= EMPTY_MARK;
			fill_q <= '0;
			use_q  <= '0;
			peak_q <= '0;
			mark_q <= '0;
		end else if (fire) begin
			head_q <= head_d;
			fill_q <= fill_d;
			use_q  <= use_d;
			peak_q <= peak_d;
			if (mark_wipe) begin
				mark_q <= '0;
			end else if (mark_set) begin
				mark_q[blk] <= 1'b1;
			end else if (mark_clr) begin
				mark_q[free_ix] <= 1'b0;
			end
		end
	end

	// Result register: hold until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status        <= status_d;
			given_index   <= gidx_d;
			given_address <= gaddr_d;
			in_use        <= COUNT_W'(use_d);
			peak_use      <= COUNT_W'(peak_d);
		end
	end

	// The two stages never hold a request at the same time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("request in both read and working stage");

	// The head is the empty marker exactly when no freed block is listed
	a_head_matches_list: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == EMPTY_MARK) == (fill_q == use_q))
		else $error("list head disagrees with listed count");

	// Blocks in use never exceed blocks issued, and the peak covers the count
	a_counts_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(use_q <= fill_q) && (peak_q >= use_q))
		else $error("use, fill and peak counts out of order");

	// A result is only produced from the working stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s2))
		else $error("result appeared without a request in the working stage");

endmodule

`default_nettype wire
